// ===== design/lpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and codes for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmd_pkg;

    // Counter, type store and queue sizing
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TYPE_COUNT      = 256;
    localparam int TYPE_AW         = $clog2(TYPE_COUNT);
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_COUNT_W     = 32;

    // Input commands
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_EOS   = 2'd1;
    localparam logic [1:0] CMD_ERROR = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_BODY      = 3'd0;
    localparam logic [2:0] KIND_SESS_END  = 3'd1;
    localparam logic [2:0] KIND_CLEAN_EOF = 3'd2;
    localparam logic [2:0] KIND_TRUNC     = 3'd3;
    localparam logic [2:0] KIND_SRC_ERR   = 3'd4;
    localparam logic [2:0] KIND_COUNT     = 3'd5;

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_BODY,
        PH_STOP
    } phase_t;

    // One classified operation handed from the front to the back
    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         data_byte;
        logic               first_byte;
        logic               last_byte;
        logic [15:0]        msg_length;
        logic [TYPE_AW-1:0] addr;
        logic               incr;
    } op_t;

endpackage

`default_nettype wire

// ===== design/lpmd_ram.sv =====
// ----------------------------------------------------------------------------
// lpmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_ram #(
    parameter int WIDTH = lpmd_pkg::COUNT_WIDTH_DEF,
    parameter int DEPTH = lpmd_pkg::TYPE_COUNT
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lpmd_front.sv =====
// ----------------------------------------------------------------------------
// lpmd_front
// Framing state machine: takes items, tracks the length prefix and body,
// and classifies each item, turning those that yield a result into an operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire logic [1:0]      cmd,
    input  wire logic [7:0]      byte_value,
    input  wire logic [7:0]      query_type,
    output logic                 push,
    output lpmd_pkg::op_t        push_op
);

    lpmd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] message_length_reg, message_length_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  current_type_reg, current_type_next;

    logic [15:0] cur_len;
    logic [15:0] new_len;
    logic        is_first;
    logic        is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= lpmd_pkg::PH_HIGH;
            length_high_reg    <= '0;
            message_length_reg <= '0;
            bytes_left_reg     <= '0;
            current_type_reg   <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            length_high_reg    <= length_high_next;
            message_length_reg <= message_length_next;
            bytes_left_reg     <= bytes_left_next;
            current_type_reg   <= current_type_next;
        end
    end

    assign cur_len  = (phase_reg == lpmd_pkg::PH_BODY) ? message_length_reg : 16'd0;
    assign new_len  = {length_high_reg, byte_value};
    assign is_first = (bytes_left_reg == message_length_reg);
    assign is_last  = (bytes_left_reg <= 16'd1);

    always_comb
    begin
        phase_next          = phase_reg;
        length_high_next    = length_high_reg;
        message_length_next = message_length_reg;
        bytes_left_next     = bytes_left_reg;
        current_type_next   = current_type_reg;
        push                = 1'b0;
        push_op             = '0;
        push_op.msg_length  = cur_len;

        if (fire)
        begin
            if (cmd == lpmd_pkg::CMD_QUERY)
            begin
                // counter reads are answered in every phase
                push         = 1'b1;
                push_op.kind = lpmd_pkg::KIND_COUNT;
                push_op.addr = query_type;
            end
            else if (phase_reg != lpmd_pkg::PH_STOP)
            begin
                unique case (cmd)
                    lpmd_pkg::CMD_ERROR:
                    begin
                        phase_next   = lpmd_pkg::PH_STOP;
                        push         = 1'b1;
                        push_op.kind = lpmd_pkg::KIND_SRC_ERR;
                    end
                    lpmd_pkg::CMD_EOS:
                    begin
                        phase_next   = lpmd_pkg::PH_STOP;
                        push         = 1'b1;
                        push_op.kind = (phase_reg == lpmd_pkg::PH_BODY && !is_first)
                                       ? lpmd_pkg::KIND_TRUNC : lpmd_pkg::KIND_CLEAN_EOF;
                    end
                    default:
                    begin
                        unique case (phase_reg)
                            lpmd_pkg::PH_HIGH:
                            begin
                                length_high_next = byte_value;
                                phase_next       = lpmd_pkg::PH_LOW;
                            end
                            lpmd_pkg::PH_LOW:
                            begin
                                if (new_len == 16'd0)
                                begin
                                    phase_next   = lpmd_pkg::PH_STOP;
                                    push         = 1'b1;
                                    push_op.kind = lpmd_pkg::KIND_SESS_END;
                                end
                                else
                                begin
                                    message_length_next = new_len;
                                    bytes_left_next     = new_len;
                                    phase_next          = lpmd_pkg::PH_BODY;
                                end
                            end
                            lpmd_pkg::PH_BODY:
                            begin
                                push               = 1'b1;
                                push_op.kind       = lpmd_pkg::KIND_BODY;
                                push_op.data_byte  = byte_value;
                                push_op.first_byte = is_first;
                                push_op.last_byte  = is_last;
                                push_op.addr       = is_first ? byte_value : current_type_reg;
                                push_op.incr       = is_last;
                                if (is_first)
                                begin
                                    current_type_next = byte_value;
                                end
                                bytes_left_next = bytes_left_reg - 16'd1;
                                if (is_last)
                                begin
                                    bytes_left_next = '0;
                                    phase_next      = lpmd_pkg::PH_HIGH;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/lpmd_queue.sv =====
// ----------------------------------------------------------------------------
// lpmd_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_queue #(
    parameter int DEPTH = lpmd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lpmd_pkg::op_t push_op,
    input  wire logic          pop,
    output lpmd_pkg::op_t      head_op,
    output logic               head_valid,
    output logic               full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpmd_pkg::op_t    slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_op    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== design/lpmd_back.sv =====
// ----------------------------------------------------------------------------
// lpmd_back
// Executes operations: reads and bumps per-type counters, keeps the total,
// and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_back #(
    parameter int COUNT_WIDTH = lpmd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lpmd_pkg::op_t head_op,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         kind,
    output logic [7:0]         data_byte,
    output logic               first_byte,
    output logic               last_byte,
    output logic [15:0]        msg_length,
    output logic [31:0]        type_count,
    output logic [31:0]        total_count
);

    localparam int AW  = lpmd_pkg::TYPE_AW;
    localparam int OW  = lpmd_pkg::OUT_COUNT_W;
    localparam int EXW = COUNT_WIDTH + OW;

    // execute stage
    logic               ex_valid_reg;
    lpmd_pkg::op_t      ex_op_reg;
    logic               ex_adv;
    logic               fwd_hit_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;
    logic               vld_hit_reg;
    logic [COUNT_WIDTH-1:0] ram_rd_data;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [EXW-1:0]     cnt_ext;
    logic [EXW-1:0]     total_ext;

    // counter store
    logic [lpmd_pkg::TYPE_COUNT-1:0] valid_bits_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic               out_valid_reg;

    assign ex_adv  = ex_valid_reg && (!out_valid_reg || !out_stall);
    assign pop     = head_valid && (!ex_valid_reg || ex_adv);

    // entries never written read as zero; last write forwarded if it hit the
    // same edge as this read
    assign cnt_cur = fwd_hit_reg ? fwd_data_reg
                   : (vld_hit_reg ? ram_rd_data : '0);
    assign cnt_inc = cnt_cur + 1'b1;

    assign wr_en   = ex_adv && ex_op_reg.incr;
    assign wr_addr = ex_op_reg.addr;

    assign total_next = total_reg + COUNT_WIDTH'(ex_op_reg.incr);
    assign cnt_ext    = {{OW{1'b0}}, cnt_cur};
    assign total_ext  = {{OW{1'b0}}, total_next};

    lpmd_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (lpmd_pkg::TYPE_COUNT)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cnt_inc),
        .rd_en   (pop),
        .rd_addr (head_op.addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_bits_reg <= '0;
            total_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_adv)
            begin
                ex_valid_reg <= 1'b0;
            end

            if (ex_adv)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (wr_en)
            begin
                valid_bits_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ex_op_reg    <= head_op;
            fwd_hit_reg  <= wr_en && (wr_addr == head_op.addr);
            fwd_data_reg <= cnt_inc;
            vld_hit_reg  <= valid_bits_reg[head_op.addr];
        end
        if (ex_adv)
        begin
            kind        <= ex_op_reg.kind;
            data_byte   <= ex_op_reg.data_byte;
            first_byte  <= ex_op_reg.first_byte;
            last_byte   <= ex_op_reg.last_byte;
            msg_length  <= ex_op_reg.msg_length;
            type_count  <= (ex_op_reg.kind == lpmd_pkg::KIND_COUNT) ? cnt_ext[OW-1:0] : '0;
            total_count <= total_ext[OW-1:0];
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_ex_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ex_valid_reg && out_valid_reg && out_stall |=> ex_valid_reg && $stable(ex_op_reg))
        else $error("execute stage lost its op under stall");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        ex_adv && ex_op_reg.incr |=> total_reg == $past(total_reg) + 1'b1)
        else $error("total not raised on completed message");

    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(ex_adv && ex_op_reg.incr) |=> total_reg == $past(total_reg))
        else $error("total changed without a completed message");

    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_bits_reg[$past(wr_addr)])
        else $error("counter entry not marked written");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind != lpmd_pkg::KIND_COUNT |-> type_count == '0)
        else $error("type count shown on a non-count result");
`endif

endmodule

`default_nettype wire

// ===== design/length_prefixed_message_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_unit
// Deframes a byte stream of 16-bit big-endian length-prefixed messages and
// keeps wrapping per-type and total message counters.
// ----------------------------------------------------------------------------
// Result path: an item that yields a result passes the queue slot written
//   at the accepting edge, the counter RAM read and the result register.
// Throughput: one item per cycle when not stalled; the counter RAM gives
//   one read and one write each cycle, write forwarded to a same-edge read.
// Reset: asynchronous; framing returns to awaiting the high length byte,
//   queue and pipeline empty, total zero, all per-type counters read as zero
//   at once through per-entry written bits (no clearing pass).
`default_nettype none

module length_prefixed_message_deframer_unit #(
    parameter int COUNT_WIDTH = lpmd_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = lpmd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  byte_value,
    input  wire logic [7:0]  query_type,
    // result output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [7:0]       data_byte,
    output logic             first_byte,
    output logic             last_byte,
    output logic [15:0]      msg_length,
    output logic [31:0]      type_count,
    output logic [31:0]      total_count
);

    logic          fire;
    logic          push;
    lpmd_pkg::op_t push_op;
    logic          pop;
    lpmd_pkg::op_t head_op;
    logic          head_valid;
    logic          q_full;

    // front only waits on queue space, never on the output side directly
    assign in_stall = q_full;
    assign fire     = in_valid && !q_full;

    // front: framing state and classification of every item
    lpmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .cmd        (cmd),
        .byte_value (byte_value),
        .query_type (query_type),
        .push       (push),
        .push_op    (push_op)
    );

    // decoupling queue; items that yield no result never enter it
    lpmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .head_op    (head_op),
        .head_valid (head_valid),
        .full       (q_full)
    );

    // back: counter store, total and result register
    lpmd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_op     (head_op),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .msg_length  (msg_length),
        .type_count  (type_count),
        .total_count (total_count)
    );

endmodule

`default_nettype wire

// ===== tb/sv/lpmd_result_checker.sv =====
// ----------------------------------------------------------------------------
// lpmd_result_checker
// Watches both channels of the deframer, predicts the result of every
// accepted item, if it yields one, and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module lpmd_result_checker
    import lpmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  byte_value,
    input  logic [7:0]  query_type,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [15:0] msg_length,
    input  logic [31:0] type_count,
    input  logic [31:0] total_count,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        is_first;
        logic        is_last;
        logic [15:0] len;
        logic [31:0] tcount;
        logic [31:0] total;
    } result_t;

    // deframer state as predicted
    phase_t      frame_phase;
    logic [7:0]  len_hi;
    logic [15:0] body_len;
    logic [15:0] body_left;
    logic [7:0]  msg_type;
    logic [31:0] type_tally [TYPE_COUNT];
    logic [31:0] msg_total;

    result_t     due_results [$];
    int          idx;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Advance the deframer by one item; queue the result it yields, if any.
    task automatic deframe_step(input logic [1:0] c, input logic [7:0] b,
                                input logic [7:0] q);
        result_t r;
        logic    emit;
        logic    started;
        r = '0;
        emit = 1'b1;
        r.len = (frame_phase == PH_BODY) ? body_len : 16'd0;
        if (c == CMD_QUERY) begin
            r.kind = KIND_COUNT;
            r.tcount = type_tally[q];
        end
        else if (frame_phase == PH_STOP) begin
            emit = 1'b0;
        end
        else if (c == CMD_ERROR) begin
            frame_phase = PH_STOP;
            r.kind = KIND_SRC_ERR;
        end
        else if (c == CMD_EOS) begin
            started = (frame_phase == PH_BODY) && (body_left != body_len);
            frame_phase = PH_STOP;
            r.kind = started ? KIND_TRUNC : KIND_CLEAN_EOF;
        end
        else begin
            case (frame_phase)
                PH_HIGH:
                begin
                    len_hi = b;
                    frame_phase = PH_LOW;
                    emit = 1'b0;
                end
                PH_LOW:
                begin
                    if ({len_hi, b} == 16'd0) begin
                        frame_phase = PH_STOP;
                        r.kind = KIND_SESS_END;
                    end
                    else begin
                        body_len = {len_hi, b};
                        body_left = {len_hi, b};
                        frame_phase = PH_BODY;
                        emit = 1'b0;
                    end
                end
                default:
                begin
                    r.kind = KIND_BODY;
                    r.data = b;
                    r.is_first = (body_left == body_len);
                    r.is_last = (body_left <= 16'd1);
                    if (r.is_first)
                        msg_type = b;
                    body_left = body_left - 16'd1;
                    if (r.is_last) begin
                        msg_total = msg_total + 32'd1;
                        type_tally[msg_type] = type_tally[msg_type] + 32'd1;
                        body_left = '0;
                        frame_phase = PH_HIGH;
                    end
                end
            endcase
        end
        r.total = msg_total;
        if (emit)
            due_results.push_back(r);
    endtask

    task automatic check_result();
        result_t want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("kind %0d arrived with nothing due", kind));
        end
        else begin
            want = due_results.pop_front();
            check_field("kind", kind, want.kind);
            check_field("data_byte", data_byte, want.data);
            check_field("first_byte", first_byte, want.is_first);
            check_field("last_byte", last_byte, want.is_last);
            check_field("msg_length", msg_length, want.len);
            check_field("type_count", type_count, want.tcount);
            check_field("total_count", total_count, want.total);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frame_phase = PH_HIGH;
            len_hi = '0;
            body_len = '0;
            body_left = '0;
            msg_type = '0;
            msg_total = '0;
            for (idx = 0; idx < TYPE_COUNT; idx++)
                type_tally[idx] = '0;
            due_results.delete();
            pending <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                deframe_step(cmd, byte_value, query_type);
            if (out_valid && !out_stall)
                check_result();
            pending <= due_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives a length-prefixed byte stream into the deframer with random idling
// on both channels; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpmd_pkg::*;

    // Ways the single session of the run may come to its end
    typedef enum {
        END_ZERO_LEN,
        END_EOS_IDLE,
        END_EOS_HALF_LEN,
        END_EOS_NO_BODY,
        END_TRUNCATED,
        END_ERR_IDLE,
        END_ERR_HALF_LEN,
        END_ERR_BODY
    } session_end_t;

    localparam int unsigned STREAM_ITEMS = 1100;  // stream part of the run
    localparam int unsigned CALM_AFTER   = 950;   // no idling from here on

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [7:0]  byte_value;
    logic [7:0]  query_type;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] msg_length;
    logic [31:0] type_count;
    logic [31:0] total_count;

    int          fail_count;
    int          pending;
    int unsigned items_sent;
    bit          calm;

    length_prefixed_message_deframer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .byte_value (byte_value),
        .query_type (query_type),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .msg_length (msg_length),
        .type_count (type_count),
        .total_count(total_count)
    );

    lpmd_result_checker result_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .byte_value (byte_value),
        .query_type (query_type),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .msg_length (msg_length),
        .type_count (type_count),
        .total_count(total_count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run, in which each item may meet
    // an idle gap on input, a receiver stall and the pipeline delay.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver back-pressure: random stall bursts, none once calm.
    initial begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one item and hold it until the deframer takes it. Valid stays
    // high into the next item unless an idle burst is drawn.
    task automatic offer_item(input logic [1:0] c, input logic [7:0] b,
                              input logic [7:0] q);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        byte_value <= b;
        query_type <= q;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    // Types are drawn mostly from a handful so that their counters climb.
    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4, 5:    return 8'($urandom_range(1, 4));
            default: return 8'($urandom);
        endcase
    endfunction

    // A counter read may land anywhere: between messages, between the two
    // length bytes or in a body.
    task automatic maybe_query();
        if ($urandom_range(0, 7) == 0)
            offer_item(CMD_QUERY, 8'($urandom), pick_type());
    endtask

    task automatic send_message(input logic [15:0] n, input logic [7:0] ty);
        int unsigned k;
        offer_item(CMD_BYTE, n[15:8], 8'($urandom));
        maybe_query();
        offer_item(CMD_BYTE, n[7:0], 8'($urandom));
        for (k = 0; k < n; k++) begin
            maybe_query();
            offer_item(CMD_BYTE, (k == 0) ? ty : 8'($urandom), 8'($urandom));
        end
    endtask

    // Short bodies mostly; now and then a long one so the upper length
    // byte gets exercised without dragging the run out.
    function automatic logic [15:0] pick_length();
        if ($urandom_range(0, 39) == 0)
            return 16'($urandom_range(256, 420));
        else if ($urandom_range(0, 5) == 0)
            return 16'd1;
        else
            return 16'($urandom_range(2, 12));
    endfunction

    // The block stops for good on any of these, and reset is never asserted
    // again, so each run takes one ending at random.
    task automatic end_session(input session_end_t how);
        logic [15:0] n;
        int unsigned k;
        n = 16'($urandom_range(16'h8000, 16'hFFFF));
        case (how)
            END_ZERO_LEN:
            begin
                offer_item(CMD_BYTE, 8'h00, 8'($urandom));
                offer_item(CMD_BYTE, 8'h00, 8'($urandom));
            end
            END_EOS_IDLE:
                offer_item(CMD_EOS, 8'($urandom), 8'($urandom));
            END_EOS_HALF_LEN:
            begin
                offer_item(CMD_BYTE, 8'($urandom), 8'($urandom));
                offer_item(CMD_EOS, 8'($urandom), 8'($urandom));
            end
            END_EOS_NO_BODY:
            begin
                offer_item(CMD_BYTE, n[15:8], 8'($urandom));
                offer_item(CMD_BYTE, n[7:0], 8'($urandom));
                offer_item(CMD_QUERY, 8'($urandom), pick_type());
                offer_item(CMD_EOS, 8'($urandom), 8'($urandom));
            end
            END_TRUNCATED, END_ERR_BODY:
            begin
                // long length, a few body bytes, then the stream breaks off
                offer_item(CMD_BYTE, n[15:8], 8'($urandom));
                offer_item(CMD_BYTE, n[7:0], 8'($urandom));
                for (k = $urandom_range(1, 5); k > 0; k--) begin
                    offer_item(CMD_BYTE, 8'($urandom), 8'($urandom));
                    maybe_query();
                end
                offer_item(CMD_QUERY, 8'($urandom), pick_type());
                offer_item((how == END_TRUNCATED) ? CMD_EOS : CMD_ERROR,
                           8'($urandom), 8'($urandom));
            end
            END_ERR_IDLE:
                offer_item(CMD_ERROR, 8'($urandom), 8'($urandom));
            default:
            begin
                offer_item(CMD_BYTE, 8'($urandom), 8'($urandom));
                offer_item(CMD_ERROR, 8'($urandom), 8'($urandom));
            end
        endcase
    endtask

    initial begin
        int unsigned k;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_BYTE;
        byte_value = '0;
        query_type = '0;
        items_sent = 0;
        calm       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: counters read zero, one-byte messages of the
        // lowest and highest type, a read between length bytes and in a body.
        offer_item(CMD_QUERY, 8'hFF, 8'h00);
        offer_item(CMD_QUERY, 8'h00, 8'hFF);
        offer_item(CMD_BYTE, 8'h00, 8'h00);
        offer_item(CMD_BYTE, 8'h01, 8'h00);
        offer_item(CMD_BYTE, 8'h00, 8'hFF);
        offer_item(CMD_QUERY, 8'h00, 8'h00);
        offer_item(CMD_BYTE, 8'h00, 8'h00);
        offer_item(CMD_QUERY, 8'hFF, 8'h80);
        offer_item(CMD_BYTE, 8'h01, 8'h00);
        offer_item(CMD_BYTE, 8'hFF, 8'h00);
        offer_item(CMD_BYTE, 8'h00, 8'h00);
        offer_item(CMD_BYTE, 8'h03, 8'h00);
        offer_item(CMD_BYTE, 8'hFF, 8'h00);
        offer_item(CMD_QUERY, 8'h00, 8'hFF);
        offer_item(CMD_BYTE, 8'h00, 8'h00);
        offer_item(CMD_BYTE, 8'h55, 8'h00);
        offer_item(CMD_QUERY, 8'h00, 8'hFF);
        offer_item(CMD_QUERY, 8'hAA, 8'h00);

        // Random part: well-formed messages with counter reads mixed in.
        while (items_sent < STREAM_ITEMS) begin
            maybe_query();
            send_message(pick_length(), pick_type());
        end

        end_session(session_end_t'($urandom_range(0, 7)));

        // Once stopped: stream bytes, end and error are dropped, reads answered.
        for (k = 0; k < 30; k++)
            offer_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lpmd_pkg.sv
design/lpmd_ram.sv
design/lpmd_front.sv
design/lpmd_queue.sv
design/lpmd_back.sv
design/length_prefixed_message_deframer_unit.sv
tb/sv/lpmd_result_checker.sv
tb/sv/tb_top.sv
